// ===== rtl/core/mdf_pkg.sv =====
package mdf_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned DIV_STEPS = 32;

  typedef enum logic [2:0] {
    OP_MUL       = 3'd0,
    OP_DIVU      = 3'd1,
    OP_DIVS      = 3'd2,
    OP_MULU_FULL = 3'd3,
    OP_MULS_FULL = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    W8  = 2'd0,
    W16 = 2'd1,
    W32 = 2'd2
  } width_t;

  typedef enum logic [1:0] {
    K_NOP  = 2'd0,
    K_MUL  = 2'd1,
    K_FULL = 2'd2,
    K_DIV  = 2'd3
  } kind_t;

  // classified item as it travels from front to back
  typedef struct packed {
    kind_t             kind;
    width_t            width;
    logic              neg;
    logic              div0;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
  } entry_t;

  // one slot of the back pipeline; rem/quo hold the product for multiplies
  typedef struct packed {
    kind_t             kind;
    width_t            width;
    logic              neg;
    logic              div0;
    logic [DATA_W-1:0] d;
    logic [DATA_W-1:0] rem;
    logic [DATA_W-1:0] quo;
  } stage_t;

  function automatic logic [DATA_W-1:0] width_mask(width_t w);
    logic [DATA_W-1:0] m;
    case (w)
      W8:      m = 32'h0000_00FF;
      W16:     m = 32'h0000_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  function automatic logic [DATA_W-1:0] width_sign(width_t w);
    logic [DATA_W-1:0] s;
    case (w)
      W8:      s = 32'h0000_0080;
      W16:     s = 32'h0000_8000;
      default: s = 32'h8000_0000;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/core/mdf_if.sv =====
interface mdf_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [1:0]  width;
  logic [31:0] operand_a;
  logic [31:0] operand_b;

  modport source (output valid, operation, width, operand_a, operand_b, input ready);
  modport sink   (input valid, operation, width, operand_a, operand_b, output ready);
endinterface

interface mdf_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_low;
  logic [31:0] result_high;
  logic        zero_flag;
  logic        negative_flag;
  logic        odd_flag;
  logic        status;

  modport source (output valid, result_low, result_high, zero_flag, negative_flag,
                  odd_flag, status, input ready);
  modport sink   (input valid, result_low, result_high, zero_flag, negative_flag,
                  odd_flag, status, output ready);
endinterface

// ===== rtl/core/mdf_front.sv =====
module mdf_front (
  mdf_in_if.sink          in,
  input  logic            full,
  output logic            push,
  output mdf_pkg::entry_t entry
);

  logic [31:0]     mask;
  logic [31:0]     sign;
  logic [31:0]     am;
  logic [31:0]     bm;
  logic            na;
  logic            nb;
  mdf_pkg::width_t w;

  assign in.ready = !full;
  assign push     = in.valid && !full;

  always_comb begin
    w     = (in.width == 2'd3) ? mdf_pkg::W32 : mdf_pkg::width_t'(in.width);
    mask  = mdf_pkg::width_mask(w);
    sign  = mdf_pkg::width_sign(w);
    am    = in.operand_a & mask;
    bm    = in.operand_b & mask;
    na    = (am & sign) != '0;
    nb    = (bm & sign) != '0;
    entry = '{kind: mdf_pkg::K_NOP, width: w, neg: 1'b0, div0: 1'b0, a: am, b: bm};
    case (in.operation)
      mdf_pkg::OP_MUL: begin
        entry.kind = mdf_pkg::K_MUL;
      end
      mdf_pkg::OP_DIVU: begin
        entry.kind = mdf_pkg::K_DIV;
        entry.div0 = (bm == '0);
      end
      mdf_pkg::OP_DIVS: begin
        // divide magnitudes, fix the sign of the quotient at the end
        entry.kind = mdf_pkg::K_DIV;
        entry.div0 = (bm == '0);
        entry.neg  = na ^ nb;
        entry.a    = na ? ((32'd0 - am) & mask) : am;
        entry.b    = nb ? ((32'd0 - bm) & mask) : bm;
      end
      mdf_pkg::OP_MULU_FULL: begin
        entry.kind  = mdf_pkg::K_FULL;
        entry.width = mdf_pkg::W32;
        entry.a     = in.operand_a;
        entry.b     = in.operand_b;
      end
      mdf_pkg::OP_MULS_FULL: begin
        entry.kind  = mdf_pkg::K_FULL;
        entry.width = mdf_pkg::W32;
        entry.neg   = in.operand_a[31] ^ in.operand_b[31];
        entry.a     = in.operand_a[31] ? (32'd0 - in.operand_a) : in.operand_a;
        entry.b     = in.operand_b[31] ? (32'd0 - in.operand_b) : in.operand_b;
      end
      default: begin
        entry.kind = mdf_pkg::K_NOP;
      end
    endcase
  end

endmodule

// ===== rtl/core/mdf_queue.sv =====
module mdf_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  mdf_pkg::entry_t push_entry,
  input  logic            pop,
  output logic            full,
  output logic            valid,
  output mdf_pkg::entry_t head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  mdf_pkg::entry_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_pop;

  assign full   = (count == CNT_W'(DEPTH));
  assign valid  = (count != '0);
  assign head   = mem[rd_ptr];
  assign do_pop = pop && valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(push) - CNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

endmodule

// ===== rtl/core/mdf_back.sv =====
module mdf_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            e_valid,
  input  mdf_pkg::entry_t e,
  output logic            advance,
  mdf_out_if.source       out
);

  localparam int unsigned N = mdf_pkg::DIV_STEPS;

  mdf_pkg::stage_t s      [N];
  mdf_pkg::stage_t s_next [N];
  logic            v      [N];
  logic            ov;
  mdf_pkg::stage_t x0;
  logic [31:0]     r_lo;
  logic [31:0]     r_hi;
  logic            r_z;
  logic            r_n;
  logic            r_o;
  logic            r_st;

  // one restoring divide step; other kinds pass through
  function automatic mdf_pkg::stage_t div_step(mdf_pkg::stage_t x);
    mdf_pkg::stage_t y;
    logic [32:0]     t;
    logic [32:0]     diff;
    logic            ge;
    y    = x;
    t    = {x.rem, x.quo[31]};
    diff = t - {1'b0, x.d};
    ge   = !diff[32];
    if (x.kind == mdf_pkg::K_DIV) begin
      y.rem = ge ? diff[31:0] : t[31:0];
      y.quo = {x.quo[30:0], ge};
    end
    return y;
  endfunction

  assign advance   = !ov || out.ready;
  assign out.valid = ov;

  always_comb begin
    x0 = '{kind: e.kind, width: e.width, neg: e.neg, div0: e.div0,
           d: e.b, rem: '0, quo: e.a};
  end

  // stage 0 also holds the multiplier, stage 1 the sign fix of signed products
  always_comb begin
    s_next[0] = div_step(x0);
    if (e.kind == mdf_pkg::K_MUL || e.kind == mdf_pkg::K_FULL) begin
      {s_next[0].rem, s_next[0].quo} = e.a * e.b;
    end
    s_next[1] = div_step(s[0]);
    if (s[0].kind == mdf_pkg::K_FULL && s[0].neg) begin
      {s_next[1].rem, s_next[1].quo} = 64'd0 - {s[0].rem, s[0].quo};
    end
    for (int k = 2; k < N; k++) begin
      s_next[k] = div_step(s[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < N; k++) begin
        v[k] <= 1'b0;
      end
      ov <= 1'b0;
    end else if (advance) begin
      v[0] <= e_valid;
      for (int k = 1; k < N; k++) begin
        v[k] <= v[k-1];
      end
      ov <= v[N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int k = 0; k < N; k++) begin
        s[k] <= s_next[k];
      end
      out.result_low    <= r_lo;
      out.result_high   <= r_hi;
      out.zero_flag     <= r_z;
      out.negative_flag <= r_n;
      out.odd_flag      <= r_o;
      out.status        <= r_st;
    end
  end

  always_comb begin
    logic [31:0] mask;
    logic [31:0] sign;
    logic [31:0] q;
    logic [31:0] res;
    mask = mdf_pkg::width_mask(s[N-1].width);
    sign = mdf_pkg::width_sign(s[N-1].width);
    q    = s[N-1].neg ? (32'd0 - s[N-1].quo) : s[N-1].quo;
    res  = '0;
    r_lo = '0;
    r_hi = '0;
    r_z  = 1'b0;
    r_n  = 1'b0;
    r_o  = 1'b0;
    r_st = 1'b0;
    case (s[N-1].kind)
      mdf_pkg::K_DIV: begin
        if (s[N-1].div0) begin
          r_st = 1'b1;
        end else begin
          res  = q & mask;
          r_lo = res;
          r_z  = (res == '0);
          r_n  = (res & sign) != '0;
          r_o  = res[0];
        end
      end
      mdf_pkg::K_MUL: begin
        res  = s[N-1].quo & mask;
        r_lo = res;
        r_z  = (res == '0);
        r_n  = (res & sign) != '0;
        r_o  = res[0];
      end
      mdf_pkg::K_FULL: begin
        r_lo = s[N-1].quo;
        r_hi = s[N-1].rem;
        r_z  = ({s[N-1].rem, s[N-1].quo} == 64'd0);
        r_n  = s[N-1].rem[31];
        r_o  = s[N-1].quo[0];
      end
      default: begin
        r_lo = '0;
      end
    endcase
  end

  a_trap_clear: assert property (@(posedge clk) disable iff (rst)
    out.valid && out.status |-> out.result_low == '0 && out.result_high == '0
      && !out.zero_flag && !out.negative_flag && !out.odd_flag)
    else $error("divide trap carries nonzero result");

  a_zero_flag: assert property (@(posedge clk) disable iff (rst)
    out.valid && out.zero_flag |-> out.result_low == '0 && !out.odd_flag)
    else $error("zero flag with nonzero low word");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> v[N-1] == $past(v[N-1]) && v[0] == $past(v[0]))
    else $error("pipeline moved while stalled");

endmodule

// ===== rtl/core/mul_div_unit_with_flags_unit.sv =====
// Integer multiply/divide unit with zero, negative and odd flags.
//
// Channels: "in" carries operation, width and two operands; "out" carries
// the low and high result words, three flags and a divide-by-zero status.
// Both are valid/ready: an item moves when valid and ready are high at a
// rising edge of clk.
//
// A front stage decodes each item (masking to width, taking magnitudes for
// signed forms) and pushes it into a small queue. The back pipeline has
// 32 stages, one restoring divide bit per stage; the multiplier sits in
// its first stage and the sign fix of signed full products in the second.
// On its way from input accept to output valid an item passes the queue,
// stage 0, 31 more divider stages and the output register. Throughput is
// one item per cycle while out.ready is high, set by the divider pipeline.
//
// When out.ready is low with a valid output, the whole back pipeline holds;
// the queue keeps taking items until it is full, then in.ready drops.
// Reset (rst, synchronous) empties the queue and clears all valid bits.
module mul_div_unit_with_flags_unit #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input logic       clk,
  input logic       rst,
  mdf_in_if.sink    in,
  mdf_out_if.source out
);

  logic            push;
  logic            full;
  logic            q_valid;
  logic            advance;
  mdf_pkg::entry_t push_entry;
  mdf_pkg::entry_t head;

  // decode and classify
  mdf_front u_front (
    .in    (in),
    .full  (full),
    .push  (push),
    .entry (push_entry)
  );

  // decouple front from back so either side can stall
  mdf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (advance),
    .full       (full),
    .valid      (q_valid),
    .head       (head)
  );

  // execute: multiply or divide, then flags
  mdf_back u_back (
    .clk     (clk),
    .rst     (rst),
    .e_valid (q_valid),
    .e       (head),
    .advance (advance),
    .out     (out)
  );

endmodule
